>>> rtl/core/dec96_pkg.sv
// ----------------------------------------------------------------------------
// dec96_pkg
// Shared widths, the power-of-ten table and the pipeline stage payload type
// for the decimal96 truncation pipeline.
// ----------------------------------------------------------------------------
package dec96_pkg;

  localparam int MAG_W       = 96;
  localparam int DIV_W       = MAG_W + 2;
  localparam int POW_W       = 128;
  localparam int SCALE_LIM   = 38;
  localparam int SCALE_IDX_W = 6;

  typedef logic [SCALE_LIM:0][POW_W-1:0] pow10_tab_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] quo;
    logic [DIV_W-1:0] divisor;
  } dec96_stage_t;

  function automatic pow10_tab_t build_pow10();
    pow10_tab_t tab;
    tab[0] = POW_W'(1);
    for (int k = 1; k <= SCALE_LIM; k++) begin
      tab[k] = tab[k-1] * POW_W'(10);
    end
    return tab;
  endfunction

  localparam pow10_tab_t POW10_TAB = build_pow10();

endpackage

>>> rtl/core/dec96_div_stage.sv
// ----------------------------------------------------------------------------
// dec96_div_stage
// One restoring division step: shift in the next dividend bit, compare
// against the divisor, subtract when it fits and record the quotient bit.
// ----------------------------------------------------------------------------
module dec96_div_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  dec96_pkg::dec96_stage_t data_i,
  output logic                   valid_o,
  output dec96_pkg::dec96_stage_t data_o
);

  logic                        valid_q;
  dec96_pkg::dec96_stage_t     data_d;
  dec96_pkg::dec96_stage_t     data_q;
  logic [dec96_pkg::MAG_W:0]   shifted;
  logic [dec96_pkg::DIV_W:0]   diff;
  logic                        take;

  always_comb begin
    shifted = {data_i.rem, data_i.quo[dec96_pkg::MAG_W-1]};
    diff    = {2'b00, shifted} - {1'b0, data_i.divisor};
    take    = ~diff[dec96_pkg::DIV_W];

    data_d         = data_i;
    data_d.rem     = take ? diff[dec96_pkg::MAG_W-1:0] : shifted[dec96_pkg::MAG_W-1:0];
    data_d.quo     = {data_i.quo[dec96_pkg::MAG_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/decimal96_truncate.sv
// ----------------------------------------------------------------------------
// decimal96_truncate
// Structure: one input register plus one restoring division stage per
// magnitude bit, 96 stages, between input transaction and result.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// result register is full and not taken.
// Reset clears the valid bits only; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
module decimal96_truncate #(
  parameter int MAGNITUDE_BITS = 96,
  parameter int MAX_SCALE      = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] magnitude_low_i,
  input  logic [31:0] magnitude_high_i,
  input  logic [4:0]  decimal_scale_i,
  input  logic        is_negative_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] integer_low_o,
  output logic [31:0] integer_high_o,
  output logic        result_negative_o
);

  localparam int MAG_W = dec96_pkg::MAG_W;
  localparam int DIV_W = dec96_pkg::DIV_W;
  localparam int POW_W = dec96_pkg::POW_W;
  localparam int IDX_W = dec96_pkg::SCALE_IDX_W;

  localparam logic [MAG_W-1:0] MagMask = (MAGNITUDE_BITS >= MAG_W) ? {MAG_W{1'b1}} :
    ({{(MAG_W-1){1'b0}}, 1'b1} << MAGNITUDE_BITS) - {{(MAG_W-1){1'b0}}, 1'b1};

  logic                    en;
  logic [IDX_W-1:0]        scale_ext;
  logic [IDX_W-1:0]        scale_eff;
  logic [POW_W-1:0]        pow;
  dec96_pkg::dec96_stage_t in_d;

  logic                    valid_s [0:MAG_W];
  dec96_pkg::dec96_stage_t data_s  [0:MAG_W];

  assign en      = !valid_s[MAG_W] || ready_i;
  assign ready_o = en;

  always_comb begin
    scale_ext = {1'b0, decimal_scale_i};
    scale_eff = (scale_ext > IDX_W'(MAX_SCALE)) ? IDX_W'(MAX_SCALE) : scale_ext;
    pow       = dec96_pkg::POW10_TAB[scale_eff];

    in_d.neg     = is_negative_i;
    in_d.rem     = '0;
    in_d.quo     = {magnitude_high_i, magnitude_low_i} & MagMask;
    in_d.divisor = (|pow[POW_W-1:DIV_W]) ? {DIV_W{1'b1}} : pow[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s[0] <= 1'b0;
    end else if (en) begin
      valid_s[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_s[0] <= in_d;
    end
  end

  for (genvar g = 0; g < MAG_W; g++) begin : g_stage
    dec96_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[g]),
      .data_i  (data_s[g]),
      .valid_o (valid_s[g+1]),
      .data_o  (data_s[g+1])
    );
  end

  assign valid_o           = valid_s[MAG_W];
  assign integer_low_o     = data_s[MAG_W].quo[63:0];
  assign integer_high_o    = data_s[MAG_W].quo[95:64];
  assign result_negative_o = data_s[MAG_W].neg;

  a_stall_only_on_full_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (valid_o && !ready_i))
    else $error("input held while output register free");

  a_divisor_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_s[0] |-> (data_s[0].divisor != '0))
    else $error("zero divisor entered pipeline");

  a_remainder_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ({2'b00, data_s[MAG_W].rem} < data_s[MAG_W].divisor))
    else $error("final remainder not below divisor");

  a_huge_divisor_zero_quotient : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (&data_s[MAG_W].divisor)) |-> (data_s[MAG_W].quo == '0))
    else $error("nonzero quotient for saturated divisor");

endmodule
